/* design/ttoi_pkg.sv */
// Package for the text-to-integer parser with a configurable digit alphabet.
// Holds the word types, parse phases, register map, reset values and character codes.
// No dependencies.
package ttoi_pkg;

    // Alphabet size limits.
    localparam int ALPHABET_MAX = 16;
    localparam int DIGIT_W      = $clog2(ALPHABET_MAX);
    localparam int LEN_W        = 5;
    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int ALPHA_W      = 64;
    localparam int ADDR_W       = 5;

    // Register reset values: digits "0123456789", base ten.
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h0000_0000_0000_3938;
    localparam logic [LEN_W-1:0]   ALPHA_LEN_RESET  = 5'd10;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Register indexes; the byte address is eight times the index.
    typedef enum logic [1:0] {
        REG_ALPHA_LOW  = 2'd0,
        REG_ALPHA_HIGH = 2'd1,
        REG_ALPHA_LEN  = 2'd2
    } reg_index_t;

    // Parse phases.
    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    // Input word.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_end;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      alphabet_ok;
    } out_word_t;

    // Digit lookup outcome.
    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] digit;
    } digit_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR) || (c == CH_SPACE);
    endfunction

    function automatic logic is_sign(input logic [CHAR_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

/* design/ttoi_alpha.sv */
// Alphabet logic: digit lookup of one character and the validity check of the alphabet.
// Depends on ttoi_pkg.
module ttoi_alpha
    import ttoi_pkg::*;
(
    input  logic [ALPHA_W-1:0] alpha_low,
    input  logic [ALPHA_W-1:0] alpha_high,
    input  logic [LEN_W-1:0]   alpha_len,
    input  logic [CHAR_W-1:0]  ch,
    output digit_t             lookup,
    output logic               alpha_ok
);

    logic [ALPHABET_MAX-1:0][CHAR_W-1:0] chars;
    logic [ALPHABET_MAX-1:0]             in_use;
    logic [ALPHABET_MAX-1:0]             hits;
    logic                                len_ok;
    logic                                bad_char;
    logic                                dup_char;

    // Unpack the alphabet and mark the positions in use.
    always_comb
    begin
        chars = {alpha_high, alpha_low};
        for (int i = 0; i < ALPHABET_MAX; i++)
        begin
            in_use[i] = LEN_W'(i) < alpha_len;
            hits[i]   = in_use[i] && (chars[i] == ch);
        end
    end

    // The first matching position gives the digit value.
    always_comb
    begin
        lookup.hit   = |hits;
        lookup.digit = '0;
        for (int i = ALPHABET_MAX - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                lookup.digit = DIGIT_W'(i);
            end
        end
    end

    // The alphabet is valid with a length in range, no sign or whitespace
    // and no repeated character.
    always_comb
    begin
        len_ok   = (alpha_len >= LEN_W'(2)) && (alpha_len <= LEN_W'(ALPHABET_MAX));
        bad_char = 1'b0;
        dup_char = 1'b0;
        for (int i = 0; i < ALPHABET_MAX; i++)
        begin
            if (in_use[i] && (is_sign(chars[i]) || is_space(chars[i])))
            begin
                bad_char = 1'b1;
            end
            for (int j = i + 1; j < ALPHABET_MAX; j++)
            begin
                if (in_use[j] && (chars[i] == chars[j]))
                begin
                    dup_char = 1'b1;
                end
            end
        end
        alpha_ok = len_ok && !bad_char && !dup_char;
    end

endmodule

/* design/text_to_integer_custom_base.sv */
// Channel | Direction | Word      | Accepted when
// text    | in        | in_word_t | text_valid && !text_stall
// result  | out       | out_word_t| result_valid && !result_stall
// config  | in (APB)  | 64-bit    | psel && penable && pwrite (pready always high)
//
// One text word is taken every cycle while text_stall is low; in the input register
// the digit lookup and the multiply-add of the accumulator are done.
// An end word passes from the input register to the result register; the 32x5 multiply-add sets the path.
// Reset restores the default alphabet "0123456789" (base ten) and clears the parse at once.
// text_stall rises only when an end word meets a full result register that is stalled.
//
// Top level of the text-to-integer parser. Depends on ttoi_pkg and ttoi_alpha.
module text_to_integer_custom_base
    import ttoi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [ALPHA_W-1:0] pwdata,
    output logic [ALPHA_W-1:0] prdata,
    output logic               pready,
    input  logic               text_valid,
    output logic               text_stall,
    input  in_word_t           text,
    output logic               result_valid,
    input  logic               result_stall,
    output out_word_t          result
);

    logic [ALPHA_W-1:0] alpha_low_reg;
    logic [ALPHA_W-1:0] alpha_high_reg;
    logic [LEN_W-1:0]   alpha_len_reg;
    logic               alpha_ok;

    logic               word_valid_reg;
    in_word_t           word_reg;
    logic               word_go;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               negative_reg;
    logic               negative_next;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [VALUE_W-1:0] acc_scaled;
    logic [VALUE_W-1:0] acc_digit;

    logic               result_valid_reg;
    out_word_t          result_reg;

    digit_t             lookup;
    logic               cfg_write;
    logic               is_minus;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= ALPHA_LOW_RESET;
            alpha_high_reg <= ALPHA_HIGH_RESET;
            alpha_len_reg  <= ALPHA_LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[ADDR_W-1:3])
                REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                REG_ALPHA_LEN:  alpha_len_reg  <= pwdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[ADDR_W-1:3])
            REG_ALPHA_LOW:  prdata = alpha_low_reg;
            REG_ALPHA_HIGH: prdata = alpha_high_reg;
            REG_ALPHA_LEN:  prdata = {{(ALPHA_W-LEN_W){1'b0}}, alpha_len_reg};
            default:        prdata = '0;
        endcase
    end

    // Alphabet lookup and validity, both against the registers as they stand now.
    ttoi_alpha u_alpha (
        .alpha_low  (alpha_low_reg),
        .alpha_high (alpha_high_reg),
        .alpha_len  (alpha_len_reg),
        .ch         (word_reg.ch),
        .lookup     (lookup),
        .alpha_ok   (alpha_ok)
    );

    // Input register: it moves on unless an end word waits on a blocked result register.
    assign word_go    = word_valid_reg &&
                        (!word_reg.is_end || !result_valid_reg || !result_stall);
    assign text_stall = word_valid_reg && !word_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            word_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall)
        begin
            word_reg <= text;
        end
    end

    // Parse phase: next state.
    always_comb
    begin
        phase_next = phase_reg;
        if (word_go)
        begin
            if (word_reg.is_end)
            begin
                phase_next = PH_SPACE;
            end
            else
            begin
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space(word_reg.ch))
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (is_sign(word_reg.ch))
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (lookup.hit)
                        begin
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (is_sign(word_reg.ch))
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (lookup.hit)
                        begin
                            phase_next = PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_DIGIT:
                    begin
                        phase_next = lookup.hit ? PH_DIGIT : PH_STOP;
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase
            end
        end
    end

    // Accumulate: acc * base, plus or minus the digit, modulo 2^32.
    assign acc_scaled = VALUE_W'(acc_reg * {{(VALUE_W-LEN_W){1'b0}}, alpha_len_reg});
    assign acc_digit  = negative_reg ?
                        acc_scaled - {{(VALUE_W-DIGIT_W){1'b0}}, lookup.digit} :
                        acc_scaled + {{(VALUE_W-DIGIT_W){1'b0}}, lookup.digit};
    assign is_minus   = word_reg.ch == CH_MINUS;

    // Parse phase: sign and accumulator outputs.
    always_comb
    begin
        negative_next = negative_reg;
        acc_next      = acc_reg;
        if (word_go)
        begin
            if (word_reg.is_end)
            begin
                negative_next = 1'b0;
                acc_next      = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space(word_reg.ch))
                        begin
                            acc_next = acc_reg;
                        end
                        else if (is_sign(word_reg.ch))
                        begin
                            negative_next = negative_reg ^ is_minus;
                        end
                        else if (lookup.hit)
                        begin
                            acc_next = acc_digit;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (is_sign(word_reg.ch))
                        begin
                            negative_next = negative_reg ^ is_minus;
                        end
                        else if (lookup.hit)
                        begin
                            acc_next = acc_digit;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (lookup.hit)
                        begin
                            acc_next = acc_digit;
                        end
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SPACE;
            negative_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            acc_reg      <= acc_next;
        end
    end

    // Result register: loaded by an end word, held while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (word_go && word_reg.is_end)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_go && word_reg.is_end)
        begin
            result_reg.value       <= alpha_ok ? acc_reg : '0;
            result_reg.alphabet_ok <= alpha_ok;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* design/ttoi_checker.sv */
// Port-level checks for text_to_integer_custom_base, attached by the bind below.
// Depends on ttoi_pkg.
module ttoi_checker
    import ttoi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      text_stall,
    input logic      result_valid,
    input logic      result_stall,
    input out_word_t result
);

    // A stalled result word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // An invalid alphabet always reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.alphabet_ok |-> result.value == '0)
        else $error("nonzero value with invalid alphabet");

    // The text side is held back only by a blocked result side.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> result_valid && result_stall)
        else $error("text stalled without a blocked result");

endmodule

bind text_to_integer_custom_base ttoi_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_stall   (text_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
